>>> rtl/mtpc_pkg.sv
// mtpc_pkg: shared types and constants of the memory test pattern checker
// no dependencies
package mtpc_pkg;

   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 9;
   localparam int unsigned CSR_AW  = 4;
   localparam int unsigned CSR_DW  = 32;

   localparam logic [BYTE_W-1:0]  PATTERN_SEED      = 8'h42;
   localparam logic [ADDR_W-1:0]  START_ADDR_RESET  = 16'h4000;
   localparam logic [ADDR_W-1:0]  END_ADDR_RESET    = 16'h7fff;
   localparam logic [BYTE_W-1:0]  ERROR_LIMIT_RESET = 8'd20;
   localparam logic [COUNT_W-1:0] COUNT_MAX         = 9'h1ff;

   localparam logic [1:0] REG_START_ADDRESS = 2'd0;
   localparam logic [1:0] REG_END_ADDRESS   = 2'd1;
   localparam logic [1:0] REG_ERROR_LIMIT   = 2'd2;

   localparam logic OPCODE_FILL   = 1'b0;
   localparam logic OPCODE_VERIFY = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic              restart;
      logic [BYTE_W-1:0] read_data;
   } in_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [BYTE_W-1:0]  pattern_byte;
      logic               mismatch;
      logic [COUNT_W-1:0] error_count;
      logic               aborted;
      logic               pass_last;
   } out_type;

   // classified step handed from front to back
   typedef struct packed {
      logic              is_verify;
      logic              is_restart;
      logic [BYTE_W-1:0] read_data;
   } op_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start_address;
      logic [ADDR_W-1:0] end_address;
      logic [BYTE_W-1:0] error_limit;
   } cfg_type;

endpackage

>>> rtl/mtpc_front.sv
// mtpc_front: input register stage, classifies each step for the back end
// depends on mtpc_pkg
module mtpc_front import mtpc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   req_valid,
   output logic   req_stall,
   input  in_type req_data,
   output logic   push_valid,
   input  logic   push_ready,
   output op_type push_op
);

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   logic   accept;

   assign req_stall  = valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = valid_ff;
   assign push_op    = op_ff;

   always_comb begin
      valid_in = accept || (valid_ff && !push_ready);
      op_in    = op_ff;
      if (accept) begin
         op_in.is_verify  = (req_data.opcode == OPCODE_VERIFY);
         op_in.is_restart = req_data.restart;
         op_in.read_data  = req_data.read_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      op_ff <= op_in;
   end

endmodule

>>> rtl/mtpc_queue.sv
// mtpc_queue: small flop-based fifo between front and back
// depends on mtpc_pkg
module mtpc_queue import mtpc_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_op,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   op_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

>>> rtl/mtpc_back.sv
// mtpc_back: pass state, pattern update, mismatch count and result register
// depends on mtpc_pkg
module mtpc_back import mtpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  op_type  pop_op,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output out_type rsp_data
);

   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [BYTE_W-1:0]  pat_ff, pat_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               abort_ff, abort_in;
   logic               valid_ff, valid_in;
   out_type            out_ff, out_in;

   logic [ADDR_W-1:0]  base_addr, next_addr;
   logic [BYTE_W-1:0]  base_pat, pat_half;
   logic [COUNT_W-1:0] base_cnt;
   logic               base_abort, miss, step;

   assign pop_ready = !valid_ff || !rsp_stall;
   assign step      = pop_valid && pop_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      base_addr  = pop_op.is_restart ? cfg.start_address : addr_ff;
      base_pat   = pop_op.is_restart ? PATTERN_SEED : pat_ff;
      base_cnt   = pop_op.is_restart ? '0 : cnt_ff;
      base_abort = pop_op.is_restart ? 1'b0 : abort_ff;

      pat_half = {base_pat[BYTE_W-2:0], 1'b0} ^ base_addr[ADDR_W-1:BYTE_W];
      pat_in   = {pat_half[BYTE_W-2:0], 1'b0} ^ ~base_addr[BYTE_W-1:0];

      miss     = pop_op.is_verify && !base_abort && (pop_op.read_data != pat_in);
      cnt_in   = base_cnt;
      abort_in = base_abort;
      if (miss) begin
         if (base_cnt != COUNT_MAX) begin
            cnt_in = base_cnt + 1'b1;
         end
         if (cnt_in > {1'b0, cfg.error_limit}) begin
            abort_in = 1'b1;
         end
      end

      next_addr = base_addr + 1'b1;
      addr_in   = next_addr;

      out_in.address      = base_addr;
      out_in.pattern_byte = pat_in;
      out_in.mismatch     = miss;
      out_in.error_count  = cnt_in;
      out_in.aborted      = abort_in;
      out_in.pass_last    = (next_addr == cfg.end_address);

      valid_in = step || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= START_ADDR_RESET;
         pat_ff   <= PATTERN_SEED;
         cnt_ff   <= '0;
         abort_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (step) begin
            addr_ff  <= addr_in;
            pat_ff   <= pat_in;
            cnt_ff   <= cnt_in;
            abort_ff <= abort_in;
         end
      end
      if (step) begin
         out_ff <= out_in;
      end
   end

endmodule

>>> rtl/memory_test_pattern_checker_unit.sv
// memory_test_pattern_checker_unit: top level, register block and front/queue/back
// depends on mtpc_pkg, mtpc_front, mtpc_queue, mtpc_back
//
//   channel  signals                                 direction
//   req      req_valid, req_stall, req_data          step transaction in
//   rsp      rsp_valid, rsp_stall, rsp_data          result transaction out
//   csr      psel, penable, pwrite, paddr, pwdata,   register access
//            prdata, pready
//
// one step per cycle sustained while rsp is not stalled; a step passes through the input register,
// the queue entry and the result register before it shows on rsp; the back end's pattern
// and count update sets the rate
// synchronous reset loads the register defaults and the pass state of a new pass
// req stalls once the queue is full and the input register is held; the queue absorbs short rsp stalls
module memory_test_pattern_checker_unit import mtpc_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  in_type             req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output out_type            rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   cfg_type cfg_ff, cfg_in;
   logic    cfg_write;
   logic    push_valid, push_ready, pop_valid, pop_ready;
   op_type  push_op, pop_op;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (paddr[3:2])
            REG_START_ADDRESS: cfg_in.start_address = pwdata[ADDR_W-1:0];
            REG_END_ADDRESS:   cfg_in.end_address   = pwdata[ADDR_W-1:0];
            REG_ERROR_LIMIT:   cfg_in.error_limit   = pwdata[BYTE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_START_ADDRESS: prdata = {{(CSR_DW-ADDR_W){1'b0}}, cfg_ff.start_address};
         REG_END_ADDRESS:   prdata = {{(CSR_DW-ADDR_W){1'b0}}, cfg_ff.end_address};
         REG_ERROR_LIMIT:   prdata = {{(CSR_DW-BYTE_W){1'b0}}, cfg_ff.error_limit};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_address <= START_ADDR_RESET;
         cfg_ff.end_address   <= END_ADDR_RESET;
         cfg_ff.error_limit   <= ERROR_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mtpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   mtpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   mtpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_op    (pop_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
